@@ rtl/sic_pkg.sv @@
// Package: shared constants and types for the segment intersection classifier.
package sic_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 16;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_PROPER  = 2'd1,
        REL_TOUCH   = 2'd2,
        REL_OVERLAP = 2'd3
    } t_relation;
endpackage

@@ rtl/sic_if.sv @@
// Interfaces: valid/ready channels for segment pairs and classification results.
interface sic_pair_if #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  p_start_x;
    logic signed [COORD_WIDTH-1:0]  p_start_y;
    logic signed [COORD_WIDTH-1:0]  p_end_x;
    logic signed [COORD_WIDTH-1:0]  p_end_y;
    logic signed [COORD_WIDTH-1:0]  q_start_x;
    logic signed [COORD_WIDTH-1:0]  q_start_y;
    logic signed [COORD_WIDTH-1:0]  q_end_x;
    logic signed [COORD_WIDTH-1:0]  q_end_y;

    modport source (output valid, p_start_x, p_start_y, p_end_x, p_end_y,
                    q_start_x, q_start_y, q_end_x, q_end_y, input ready);
    modport sink   (input valid, p_start_x, p_start_y, p_end_x, p_end_y,
                    q_start_x, q_start_y, q_end_x, q_end_y, output ready);
endinterface

interface sic_result_if #(
    parameter int FRAC_BITS = sic_pkg::FRAC_BITS
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            relation;
    logic [FRAC_BITS-1:0]  t_fraction;
    logic [FRAC_BITS-1:0]  u_fraction;
    logic                  zero_length_first;

    modport source (output valid, relation, t_fraction, u_fraction, zero_length_first,
                    input ready);
    modport sink   (input valid, relation, t_fraction, u_fraction, zero_length_first,
                    output ready);
endinterface

@@ rtl/sic_div_stage.sv @@
// Module: one restoring-division step for both fractions, pipelined.
module sic_div_stage #(
    parameter int PW = 51
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [PW-1:0] i_den,
    input  logic [PW-1:0] i_t_rem,
    input  logic [PW-1:0] i_u_rem,
    input  logic          i_t_bit_in_unused_guard,
    output logic [PW-1:0] o_t_rem,
    output logic [PW-1:0] o_u_rem,
    output logic          o_t_bit,
    output logic          o_u_bit
);
    logic [PW:0] n_t2;
    logic [PW:0] n_u2;
    logic        n_tge;
    logic        n_uge;

    always_comb begin
        n_t2  = {i_t_rem, 1'b0};
        n_u2  = {i_u_rem, 1'b0};
        n_tge = (n_t2 >= {1'b0, i_den}) && !i_t_bit_in_unused_guard;
        n_uge = (n_u2 >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_t_rem <= n_tge ? PW'(n_t2 - {1'b0, i_den}) : PW'(n_t2);
            o_u_rem <= n_uge ? PW'(n_u2 - {1'b0, i_den}) : PW'(n_u2);
            o_t_bit <= n_tge;
            o_u_bit <= n_uge;
        end
    end
endmodule

@@ rtl/segment_intersection_classify.sv @@
// Top level: pipelined segment pair classifier with fraction dividers.
// Usage:
//   i_pair (sink): one beat carries segments P (p_start->p_end) and Q
//   (q_start->q_end) as signed grid coordinates.
//   o_result (source): one beat per pair with relation (none, proper,
//   touch, collinear overlap), t/u fractions in Q0.FRAC_BITS for proper
//   crossings, and a flag for a zero-length P.
// Throughput: one pair per cycle while the receiver takes each result beat; every stage advances together.
// Pipeline: from accepted pair to result beat, registered stages for
//   differences, products, cross-product sums and classify, then one
//   restoring-division step per fraction bit.
// Stall: the whole pipeline holds while the last stage carries a beat the
//   receiver has not taken; ready toward the source drops only then.
// Reset: clears every stage valid bit; payload registers are not reset.
module segment_intersection_classify #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = sic_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sic_pair_if.sink    i_pair,
    sic_result_if.source o_result
);
    localparam int DW = COORD_WIDTH + 1;   // coordinate differences
    localparam int MW = 2 * DW;            // products
    localparam int PW = MW + 1;            // cross products
    localparam int NS = FRAC_BITS + 4;     // total stages

    // Advance everything unless the output beat is stuck.
    logic adv;
    assign adv = !o_result.valid || o_result.ready;
    assign i_pair.ready = adv;

    logic [NS-1:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_pair.valid};
        end
    end

    // Stage 1: differences.
    logic signed [DW-1:0] r_rx, r_ry, r_sx, r_sy, r_dx, r_dy, r_ex, r_ey;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rx <= DW'(i_pair.p_end_x)   - DW'(i_pair.p_start_x);
            r_ry <= DW'(i_pair.p_end_y)   - DW'(i_pair.p_start_y);
            r_sx <= DW'(i_pair.q_end_x)   - DW'(i_pair.q_start_x);
            r_sy <= DW'(i_pair.q_end_y)   - DW'(i_pair.q_start_y);
            r_dx <= DW'(i_pair.q_start_x) - DW'(i_pair.p_start_x);
            r_dy <= DW'(i_pair.q_start_y) - DW'(i_pair.p_start_y);
            r_ex <= DW'(i_pair.q_end_x)   - DW'(i_pair.p_start_x);
            r_ey <= DW'(i_pair.q_end_y)   - DW'(i_pair.p_start_y);
        end
    end

    // Stage 2: six products, plus collinear projection operands.
    logic signed [MW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [DW:0]   r_pd, r_pa2, r_pa3;
    logic                 r_zl2;
    logic [DW-1:0]        n_arx, n_ary;
    logic signed [DW:0]   n_d, n_a2, n_a3;
    always_comb begin
        n_arx = r_rx[DW-1] ? DW'(-r_rx) : DW'(r_rx);
        n_ary = r_ry[DW-1] ? DW'(-r_ry) : DW'(r_ry);
        if (n_arx >= n_ary) begin
            n_d = (DW+1)'(r_rx); n_a2 = (DW+1)'(r_dx); n_a3 = (DW+1)'(r_ex);
        end else begin
            n_d = (DW+1)'(r_ry); n_a2 = (DW+1)'(r_dy); n_a3 = (DW+1)'(r_ey);
        end
        if (n_d < 0) begin
            n_d = -n_d; n_a2 = -n_a2; n_a3 = -n_a3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0  <= MW'(r_rx) * MW'(r_sy);
            r_m1  <= MW'(r_ry) * MW'(r_sx);
            r_m2  <= MW'(r_dx) * MW'(r_sy);
            r_m3  <= MW'(r_dy) * MW'(r_sx);
            r_m4  <= MW'(r_dx) * MW'(r_ry);
            r_m5  <= MW'(r_dy) * MW'(r_rx);
            r_pd  <= n_d;
            r_pa2 <= n_a2;
            r_pa3 <= n_a3;
            r_zl2 <= (r_rx == '0) && (r_ry == '0);
        end
    end

    // Stage 3: cross products, sign normalized; collinear decision.
    logic signed [PW-1:0] r_den, r_tn, r_un;
    logic                 r_zl3, r_col3;
    logic signed [PW-1:0] n_den, n_tn, n_un;
    always_comb begin
        n_den = PW'(r_m0) - PW'(r_m1);
        n_tn  = PW'(r_m2) - PW'(r_m3);
        n_un  = PW'(r_m4) - PW'(r_m5);
        if (n_den < 0) begin
            n_den = -n_den; n_tn = -n_tn; n_un = -n_un;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den  <= n_den;
            r_tn   <= n_tn;
            r_un   <= n_un;
            r_zl3  <= r_zl2;
            r_col3 <= !((r_pa2 < 0 && r_pa3 < 0) || (r_pa2 > r_pd && r_pa3 > r_pd));
        end
    end

    // Stage 4: classify; seed the dividers.
    sic_pkg::t_relation n_rel;
    always_comb begin
        if (r_zl3) begin
            n_rel = sic_pkg::REL_NONE;
        end else if (r_den == '0) begin
            n_rel = (r_un == '0 && r_col3) ? sic_pkg::REL_OVERLAP : sic_pkg::REL_NONE;
        end else if (r_tn > 0 && r_tn < r_den && r_un > 0 && r_un < r_den) begin
            n_rel = sic_pkg::REL_PROPER;
        end else if (r_tn >= 0 && r_tn <= r_den && r_un >= 0 && r_un <= r_den) begin
            n_rel = sic_pkg::REL_TOUCH;
        end else begin
            n_rel = sic_pkg::REL_NONE;
        end
    end

    logic [1:0]    r_rel   [FRAC_BITS+1];
    logic          r_zl    [FRAC_BITS+1];
    logic [PW-1:0] r_dd    [FRAC_BITS+1];
    logic [PW-1:0] r_trem  [FRAC_BITS+1];
    logic [PW-1:0] r_urem  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_tq [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_uq [FRAC_BITS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rel[0]  <= n_rel;
            r_zl[0]   <= r_zl3;
            // Non-proper beats divide zero by one so every quotient bit stays 0.
            r_dd[0]   <= (n_rel == sic_pkg::REL_PROPER) ? r_den : PW'(1);
            r_trem[0] <= (n_rel == sic_pkg::REL_PROPER) ? r_tn : '0;
            r_urem[0] <= (n_rel == sic_pkg::REL_PROPER) ? r_un : '0;
            r_tq[0]   <= '0;
            r_uq[0]   <= '0;
        end
    end

    // No quotient bits yet beside the first division step.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tq[1] <= r_tq[0];
            r_uq[1] <= r_uq[0];
        end
    end

    // Division steps: one quotient bit per stage.
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
        logic t_bit, u_bit;
        sic_div_stage #(.PW(PW)) u_step (
            .i_clk                  (i_clk),
            .i_en                   (adv),
            .i_den                  (r_dd[k]),
            .i_t_rem                (r_trem[k]),
            .i_u_rem                (r_urem[k]),
            .i_t_bit_in_unused_guard(1'b0),
            .o_t_rem                (r_trem[k+1]),
            .o_u_rem                (r_urem[k+1]),
            .o_t_bit                (t_bit),
            .o_u_bit                (u_bit)
        );
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rel[k+1] <= r_rel[k];
                r_zl[k+1]  <= r_zl[k];
                r_dd[k+1]  <= r_dd[k];
            end
        end
        // Quotient bit k lands at position FRAC_BITS-1-k.
        logic [FRAC_BITS-1:0] tq_full, uq_full;
        always_comb begin
            tq_full = r_tq[k+1];
            uq_full = r_uq[k+1];
            tq_full[FRAC_BITS-1-k] = t_bit;
            uq_full[FRAC_BITS-1-k] = u_bit;
        end
        if (k == FRAC_BITS - 1) begin : g_last
            assign o_result.t_fraction = tq_full;
            assign o_result.u_fraction = uq_full;
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_tq[k+2] <= tq_full;
                    r_uq[k+2] <= uq_full;
                end
            end
        end
    end

    assign o_result.valid             = r_v[NS-1];
    assign o_result.relation          = r_rel[FRAC_BITS];
    assign o_result.zero_length_first = r_zl[FRAC_BITS];
endmodule

@@ rtl/sic_checker.sv @@
// Checker: port-level assertions for the segment intersection classifier.
module sic_checker #(
    parameter int FRAC_BITS = sic_pkg::FRAC_BITS
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           i_relation,
    input logic [FRAC_BITS-1:0] i_t_fraction,
    input logic [FRAC_BITS-1:0] i_u_fraction,
    input logic                 i_zero_length_first
);
    a_frac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_relation != sic_pkg::REL_PROPER |->
            i_t_fraction == '0 && i_u_fraction == '0)
        else $error("fractions nonzero on a non-proper result");
    a_zl_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_length_first |-> i_relation == sic_pkg::REL_NONE)
        else $error("zero-length first segment with a relation");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_relation))
        else $error("stalled result beat changed");
endmodule

bind segment_intersection_classify sic_checker #(.FRAC_BITS(FRAC_BITS)) u_sic_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_pair.ready),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_relation          (o_result.relation),
    .i_t_fraction        (o_result.t_fraction),
    .i_u_fraction        (o_result.u_fraction),
    .i_zero_length_first (o_result.zero_length_first)
);

@@ verif/segment_intersection_classify_tb.sv @@
// Testbench: checks the segment pair classifier against a predictor under random idling.
`timescale 1ns / 1ps

module segment_intersection_classify_tb;
    localparam int CW = sic_pkg::COORD_WIDTH;
    localparam int FB = sic_pkg::FRAC_BITS;
    localparam int LATENCY = FB + 4;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CW-1:0] t_coord;

    // One beat of the pair channel: P start, P end, Q start, Q end.
    typedef struct {
        t_coord px1, py1, px2, py2, qx1, qy1, qx2, qy2;
    } t_seg_pair;

    typedef struct {
        sic_pkg::t_relation relation;
        logic [FB-1:0]      t_fraction;
        logic [FB-1:0]      u_fraction;
        logic               zero_length_first;
    } t_classification;

    // Work out the classification of one pair with exact cross products.
    function automatic t_classification classify_pair(t_seg_pair s);
        t_classification c;
        longint rx, ry, sx, sy, dx, dy, den, tn, un, span, a2, a3;
        c.relation = sic_pkg::REL_NONE;
        c.t_fraction = '0;
        c.u_fraction = '0;
        c.zero_length_first = 1'b0;
        rx = longint'(s.px2) - longint'(s.px1);
        ry = longint'(s.py2) - longint'(s.py1);
        sx = longint'(s.qx2) - longint'(s.qx1);
        sy = longint'(s.qy2) - longint'(s.qy1);
        dx = longint'(s.qx1) - longint'(s.px1);
        dy = longint'(s.qy1) - longint'(s.py1);
        if (rx == 0 && ry == 0) begin
            c.zero_length_first = 1'b1;
            return c;
        end
        den = rx * sy - ry * sx;
        tn = dx * sy - dy * sx;
        un = dx * ry - dy * rx;
        if (den == 0) begin
            if (un == 0) begin
                // Project Q's ends onto P's dominant axis.
                if ((rx < 0 ? -rx : rx) >= (ry < 0 ? -ry : ry)) begin
                    span = rx; a2 = dx; a3 = longint'(s.qx2) - longint'(s.px1);
                end else begin
                    span = ry; a2 = dy; a3 = longint'(s.qy2) - longint'(s.py1);
                end
                if (span < 0) begin
                    span = -span; a2 = -a2; a3 = -a3;
                end
                if (!((a2 < 0 && a3 < 0) || (a2 > span && a3 > span)))
                    c.relation = sic_pkg::REL_OVERLAP;
            end
            return c;
        end
        if (den < 0) begin
            den = -den; tn = -tn; un = -un;
        end
        if (tn > 0 && tn < den && un > 0 && un < den) begin
            c.relation = sic_pkg::REL_PROPER;
            c.t_fraction = FB'((128'(tn) << FB) / 128'(den));
            c.u_fraction = FB'((128'(un) << FB) / 128'(den));
        end else if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
            c.relation = sic_pkg::REL_TOUCH;
        end
        return c;
    endfunction

    class classification_board;
        t_classification pending[$];
        int mismatches;

        function void note_pair(t_seg_pair s);
            pending = {pending, classify_pair(s)};
        endfunction

        function void check_result(t_classification got);
            t_classification want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: rel %0d", got.relation);
                return;
            end
            want = pending.pop_front();
            if (got.relation !== want.relation || got.t_fraction !== want.t_fraction ||
                got.u_fraction !== want.u_fraction ||
                got.zero_length_first !== want.zero_length_first) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want rel %0d t %h u %h z %b, got rel %0d t %h u %h z %b",
                             want.relation, want.t_fraction, want.u_fraction,
                             want.zero_length_first, got.relation, got.t_fraction,
                             got.u_fraction, got.zero_length_first);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sic_pair_if   pair_ch();
    sic_result_if result_ch();

    segment_intersection_classify DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (pair_ch.sink),
        .o_result (result_ch.source)
    );

    classification_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    longint cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: drop ready at random; check each beat taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                board.check_result('{sic_pkg::t_relation'(result_ch.relation),
                                     result_ch.t_fraction, result_ch.u_fraction,
                                     result_ch.zero_length_first});
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one pair; hold it until accepted, with random idle cycles first.
    task automatic send_pair(t_seg_pair s);
        while ($urandom_range(99) < send_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_ch.valid     <= 1'b1;
        pair_ch.p_start_x <= s.px1;
        pair_ch.p_start_y <= s.py1;
        pair_ch.p_end_x   <= s.px2;
        pair_ch.p_end_y   <= s.py2;
        pair_ch.q_start_x <= s.qx1;
        pair_ch.q_start_y <= s.qy1;
        pair_ch.q_end_x   <= s.qx2;
        pair_ch.q_end_y   <= s.qy2;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        board.note_pair(s);
    endtask

    function automatic t_seg_pair make_pair(t_coord a, t_coord b, t_coord c, t_coord d,
                                            t_coord e, t_coord f, t_coord g, t_coord h);
        t_seg_pair s;
        s.px1 = a; s.py1 = b; s.px2 = c; s.py2 = d;
        s.qx1 = e; s.qy1 = f; s.qx2 = g; s.qy2 = h;
        return s;
    endfunction

    // Coordinate with small, medium, wide or extreme range to hit every bit and edge.
    function automatic t_coord rand_coord();
        case ($urandom_range(3))
            0: return t_coord'($signed($urandom_range(40)) - 20);
            1: return t_coord'($urandom);
            2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return t_coord'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // Shaped pair: crossing, touching, collinear, parallel, zero-length or free.
    function automatic t_seg_pair rand_pair();
        t_seg_pair s;
        t_coord ox, oy, vx, vy;
        int k1, k2;
        s = make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
        ox = t_coord'($signed($urandom_range(2000)) - 1000);
        oy = t_coord'($signed($urandom_range(2000)) - 1000);
        vx = t_coord'($signed($urandom_range(200)) - 100);
        vy = t_coord'($signed($urandom_range(200)) - 100);
        k1 = $signed($urandom_range(8)) - 4;
        k2 = $signed($urandom_range(8)) - 4;
        case ($urandom_range(5))
            0: begin  // crossing about a common point
                s.px1 = ox - vx; s.py1 = oy - vy; s.px2 = ox + vx; s.py2 = oy + vy;
                s.qx1 = ox + vy; s.qy1 = oy - vx;
                s.qx2 = t_coord'(ox - 2*vy); s.qy2 = t_coord'(oy + 2*vx);
            end
            1: begin  // Q starts at an endpoint of P
                s.px1 = ox; s.py1 = oy; s.px2 = ox + vx; s.py2 = oy + vy;
                s.qx1 = $urandom_range(1) ? s.px1 : s.px2;
                s.qy1 = (s.qx1 == s.px1) ? s.py1 : s.py2;
            end
            2: begin  // collinear with random spans
                s.px1 = ox; s.py1 = oy;
                s.px2 = t_coord'(ox + 2*vx); s.py2 = t_coord'(oy + 2*vy);
                s.qx1 = t_coord'(ox + k1*vx); s.qy1 = t_coord'(oy + k1*vy);
                s.qx2 = t_coord'(ox + k2*vx); s.qy2 = t_coord'(oy + k2*vy);
            end
            3: begin  // parallel, offset
                s.px1 = ox; s.py1 = oy; s.px2 = ox + vx; s.py2 = oy + vy;
                s.qx1 = t_coord'(ox + 1); s.qy1 = t_coord'(oy + 3);
                s.qx2 = t_coord'(s.qx1 + k1*vx); s.qy2 = t_coord'(s.qy1 + k1*vy);
            end
            4: begin  // zero-length P
                s.px2 = s.px1; s.py2 = s.py1;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic run_phase(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pair(rand_pair());
    endtask

    localparam t_coord CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(CW-1){1'b0}}};

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        pair_ch.valid = 1'b0;
        {pair_ch.p_start_x, pair_ch.p_start_y, pair_ch.p_end_x, pair_ch.p_end_y} = '0;
        {pair_ch.q_start_x, pair_ch.q_start_y, pair_ch.q_end_x, pair_ch.q_end_y} = '0;
        result_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each relation, zero-length P and Q, extremes of the grid.
        send_idle_pct = 33;
        recv_idle_pct = 71;
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));       // proper crossing
        send_pair(make_pair(0, 0, 7, 3, 1, 5, 6, -2));          // proper, both fractions one half
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 5));          // touch at Q start
        send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 7));        // touch at P end
        send_pair(make_pair(0, 0, 10, 0, 5, -5, 5, 5));         // proper crossing at both midpoints
        send_pair(make_pair(0, 0, 10, 0, 20, -5, 20, 5));       // lines cross outside
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));         // collinear overlap
        send_pair(make_pair(0, 0, 10, 0, 11, 0, 15, 0));        // collinear past end
        send_pair(make_pair(0, 0, 10, 0, -4, 0, -1, 0));        // collinear before start
        send_pair(make_pair(0, 0, 0, 10, 0, 12, 0, -3));        // vertical, covers P
        send_pair(make_pair(10, 10, 0, 0, 5, 5, 20, 20));       // reversed P, overlap
        send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));         // parallel off line
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 5, 5));           // zero-length P
        send_pair(make_pair(0, 0, 10, 0, 4, 0, 4, 0));          // zero-length Q on P
        send_pair(make_pair(0, 0, 10, 0, 4, 2, 4, 2));          // zero-length Q off line
        send_pair(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_pair(make_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
        send_pair(make_pair(CMIN, 0, CMAX, 1, 0, CMIN, 1, CMAX));
        send_pair(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN));
        send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));

        run_phase(33, 71, 600);
        run_phase(71, 33, 600);
        run_phase(0, 0, 600);
        pair_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ segment_intersection_classify.f @@
rtl/sic_pkg.sv
rtl/sic_if.sv
rtl/sic_div_stage.sv
rtl/segment_intersection_classify.sv
rtl/sic_checker.sv
verif/segment_intersection_classify_tb.sv
